// ----- design/rtld_pkg.sv -----
// shared types and constants of the row tile run/literal decoder
package rtld_pkg;

   // width of the count field of a control byte and the literal flag position
   localparam int COUNT_W = 7;
   localparam int LIT_BIT = 7;

   // input modes
   localparam logic [1:0] MODE_LOAD  = 2'd0;
   localparam logic [1:0] MODE_BYTE  = 2'd1;
   localparam logic [1:0] MODE_START = 2'd2;

   // one input item
   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] stream_byte;
      logic [7:0] entry_index;
      logic [7:0] entry_char;
      logic [3:0] entry_colour;
   } req_type;

   // one result item
   typedef struct packed {
      logic [9:0] cell_offset;
      logic [7:0] char_code;
      logic [3:0] colour_value;
      logic       last_of_item;
      logic       picture_done;
   } rsp_type;

   // one tile table entry
   typedef struct packed {
      logic [7:0] char_code;
      logic [3:0] colour;
   } tile_entry_type;

   // tile table write request
   typedef struct packed {
      logic           en;
      logic [7:0]     index;
      tile_entry_type entry;
   } tile_wr_type;

endpackage

// ----- design/rtld_tile_mem.sv -----
// tile table memory with range checked write and registered read
module rtld_tile_mem #(
   parameter int TILE_COUNT = 256
) (
   input  logic                    clock,
   input  rtld_pkg::tile_wr_type   wr,
   input  logic                    rd_en,
   input  logic [7:0]              rd_index,
   output rtld_pkg::tile_entry_type rd_entry
);

   localparam int IDX_W = $clog2(TILE_COUNT);

   rtld_pkg::tile_entry_type mem [TILE_COUNT];
   rtld_pkg::tile_entry_type rd_data_ff;
   logic                     rd_oor_ff;
   logic                     wr_in_range;
   logic                     rd_in_range;

   assign wr_in_range = ({1'b0, wr.index} < 9'(TILE_COUNT));
   assign rd_in_range = ({1'b0, rd_index} < 9'(TILE_COUNT));

   // write port, indexes beyond the table are dropped
   always_ff @(posedge clock) begin
      if (wr.en && wr_in_range) begin
         mem[wr.index[IDX_W-1:0]] <= wr.entry;
      end
   end

   // read port, registered, held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_index[IDX_W-1:0]];
         rd_oor_ff  <= !rd_in_range;
      end
   end

   // out of range tiles read as blank
   assign rd_entry = rd_oor_ff ? '0 : rd_data_ff;

endmodule

// ----- design/row_tile_run_literal_decoder.sv -----
// row tile run/literal decoder: control bytes and tile bytes in, screen cells out
// order: a tile byte's table entry is read into the tile table read register, then its first
// cell goes into the single cell output register once that is free; further input waits until
// all cells of a tile byte (one for a literal tile) are in it; control, load and start bytes wait on nothing
// reset: synchronous, clears position, phase and handshake state; tile table keeps its contents
module row_tile_run_literal_decoder #(
   parameter int PICTURE_ROWS = 16,
   parameter int ROW_CELLS    = 40,
   parameter int TILE_COUNT   = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rtld_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rtld_pkg::rsp_type rsp_data
);

   localparam int COL_W = $clog2(ROW_CELLS);
   localparam int CNT_W = $clog2(ROW_CELLS + 1);
   localparam int ROW_W = (PICTURE_ROWS > 1) ? $clog2(PICTURE_ROWS) : 1;

   typedef enum logic {ST_IDLE, ST_EMIT} state_type;
   typedef enum logic [1:0] {PH_CTRL, PH_RUN, PH_LIT} phase_type;

   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [CNT_W-1:0]         remaining_ff, remaining_in;
   logic [CNT_W-1:0]         cells_ff, cells_in;
   logic [COL_W-1:0]         column_ff, column_in;
   logic [ROW_W-1:0]         row_ff, row_in;
   logic [9:0]               offset_ff, offset_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rtld_pkg::rsp_type        rsp_ff, rsp_in;

   rtld_pkg::tile_wr_type    tile_wr;
   logic                     rd_en;
   rtld_pkg::tile_entry_type rd_entry;

   logic                     out_free;
   logic [rtld_pkg::COUNT_W-1:0] count_raw;
   logic [rtld_pkg::COUNT_W-1:0] cols_left;
   logic [rtld_pkg::COUNT_W-1:0] count_clip;
   logic                     last_col;
   logic                     last_row;

   // tile table
   rtld_tile_mem #(
      .TILE_COUNT (TILE_COUNT)
   ) u_tile_mem (
      .clock    (clock),
      .wr       (tile_wr),
      .rd_en    (rd_en),
      .rd_index (req_data.stream_byte),
      .rd_entry (rd_entry)
   );

   // count clipping against the cells left in the row
   assign count_raw  = req_data.stream_byte[rtld_pkg::COUNT_W-1:0];
   assign cols_left  = rtld_pkg::COUNT_W'(ROW_CELLS) - rtld_pkg::COUNT_W'(column_ff);
   assign count_clip = (count_raw > cols_left) ? cols_left : count_raw;

   // position wrap points
   assign last_col = (column_ff == COL_W'(ROW_CELLS - 1));
   assign last_row = (row_ff == ROW_W'(PICTURE_ROWS - 1));

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // next state
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      cells_in     = cells_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      tile_wr.en    = 1'b0;
      tile_wr.index = req_data.entry_index;
      tile_wr.entry.char_code = req_data.entry_char;
      tile_wr.entry.colour    = req_data.entry_colour;
      rd_en        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.mode)
                  rtld_pkg::MODE_LOAD: begin
                     tile_wr.en = 1'b1;
                  end
                  rtld_pkg::MODE_START: begin
                     phase_in     = PH_CTRL;
                     remaining_in = '0;
                     column_in    = '0;
                     row_in       = '0;
                     offset_in    = '0;
                  end
                  rtld_pkg::MODE_BYTE: begin
                     unique case (phase_ff)
                        PH_CTRL: begin
                           // zero counts leave the control phase as it is
                           if (count_clip != '0) begin
                              remaining_in = CNT_W'(count_clip);
                              phase_in = req_data.stream_byte[rtld_pkg::LIT_BIT] ?
                                         PH_LIT : PH_RUN;
                           end
                        end
                        PH_RUN: begin
                           rd_en        = 1'b1;
                           cells_in     = remaining_ff;
                           remaining_in = '0;
                           phase_in     = PH_CTRL;
                           state_in     = ST_EMIT;
                        end
                        PH_LIT: begin
                           rd_en        = 1'b1;
                           cells_in     = CNT_W'(1);
                           remaining_in = remaining_ff - CNT_W'(1);
                           if (remaining_ff == CNT_W'(1)) begin
                              phase_in = PH_CTRL;
                           end
                           state_in = ST_EMIT;
                        end
                        default: begin
                           phase_in = PH_CTRL;
                        end
                     endcase
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EMIT: begin
            // one cell per cycle into the output register, while the output register is free
            if (out_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.cell_offset  = offset_ff;
               rsp_in.char_code    = rd_entry.char_code;
               rsp_in.colour_value = rd_entry.colour;
               rsp_in.last_of_item = (cells_ff == CNT_W'(1));
               rsp_in.picture_done = last_col && last_row;
               cells_in = cells_ff - CNT_W'(1);
               if (cells_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
               if (last_col) begin
                  column_in = '0;
                  row_in    = last_row ? '0 : row_ff + ROW_W'(1);
               end else begin
                  column_in = column_ff + COL_W'(1);
               end
               offset_in = (last_col && last_row) ? '0 : offset_ff + 10'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_CTRL;
         remaining_ff <= '0;
         cells_ff     <= '0;
         column_ff    <= '0;
         row_ff       <= '0;
         offset_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         cells_ff     <= cells_in;
         column_ff    <= column_in;
         row_ff       <= row_in;
         offset_ff    <= offset_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   // emission always has a cell to send
   a_emit_has_cells: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (cells_ff != '0))
      else $error("emit state with no cells left");

   // a run or literal phase always has a nonzero count
   a_phase_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_CTRL) |-> (remaining_ff != '0))
      else $error("data phase with zero count");

   // column stays inside the row
   a_column_range: assert property (@(posedge clock) disable iff (reset)
      (column_ff <= COL_W'(ROW_CELLS - 1)))
      else $error("column beyond row end");

   // end of picture falls on the last cell of the picture
   a_done_offset: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.picture_done) |->
      (rsp_ff.cell_offset == 10'(PICTURE_ROWS * ROW_CELLS - 1)))
      else $error("picture done at wrong offset");

   // a tile byte in a data phase starts emission
   a_tile_starts_emit: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.mode == rtld_pkg::MODE_BYTE &&
       phase_ff != PH_CTRL) |=> (state_ff == ST_EMIT))
      else $error("tile byte did not start emission");
`endif

endmodule

// ----- test/row_tile_run_literal_decoder_test.sv -----
// testbench of the row tile run/literal decoder: directed table, then random streams
module row_tile_run_literal_decoder_test;

   localparam int PICTURE_ROWS = 16;
   localparam int ROW_CELLS    = 40;
   localparam int TILE_COUNT   = 256;
   localparam int RANDOM_ITEMS = 200;
   localparam int DIR_ROWS     = 24;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 300000;

   // mode code the block ignores
   localparam logic [1:0]        MODE_UNUSED = 2'd3;
   localparam rtld_pkg::rsp_type NO_CELL     = '0;

   typedef enum logic [1:0] {
      EXPECT_CTRL,
      EXPECT_RUN_TILE,
      EXPECT_LIT_TILE
   } stream_phase_type;

   // one row of the directed table, with a typed-in cell where it is obvious
   typedef struct packed {
      rtld_pkg::req_type item;
      logic              typed;
      rtld_pkg::rsp_type want_cell;
   } directed_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   rtld_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rtld_pkg::rsp_type rsp_data;

   // predictor state
   stream_phase_type         tile_phase;
   int unsigned              tiles_left;
   int unsigned              cell_column;
   int unsigned              cell_row;
   rtld_pkg::tile_entry_type tile_copy [TILE_COUNT];
   logic [TILE_COUNT-1:0]    tile_loaded;
   int unsigned              loaded_list [$];
   rtld_pkg::rsp_type        cells_due [$];

   bit                    idle_on;
   int                    error_count;
   int unsigned           cycle_count;
   int unsigned           stall_left;
   directed_row_type      directed_rows [DIR_ROWS];

   row_tile_run_literal_decoder #(
      .PICTURE_ROWS(PICTURE_ROWS),
      .ROW_CELLS   (ROW_CELLS),
      .TILE_COUNT  (TILE_COUNT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // one screen cell at the current position, then advance column and row
   function automatic void emit_cell(input logic [7:0] tile, input logic last);
      rtld_pkg::rsp_type next_cell;
      next_cell.cell_offset  = 10'((cell_row * ROW_CELLS + cell_column) & 32'h3ff);
      next_cell.char_code    = tile_copy[tile].char_code;
      next_cell.colour_value = tile_copy[tile].colour;
      next_cell.last_of_item = last;
      next_cell.picture_done = 1'b0;
      cell_column++;
      if (cell_column >= ROW_CELLS) begin
         cell_column = 0;
         cell_row++;
         if (cell_row >= PICTURE_ROWS) begin
            cell_row = 0;
            next_cell.picture_done = 1'b1;
         end
      end
      cells_due.push_back(next_cell);
   endfunction

   // cells caused by one accepted transfer
   function automatic void decode_item(input rtld_pkg::req_type item);
      int unsigned count;
      case (item.mode)
         rtld_pkg::MODE_LOAD: begin
            tile_copy[item.entry_index] = {item.entry_char, item.entry_colour};
            if (!tile_loaded[item.entry_index])
               loaded_list.push_back(32'(item.entry_index));
            tile_loaded[item.entry_index] = 1'b1;
         end
         rtld_pkg::MODE_START: begin
            tile_phase  = EXPECT_CTRL;
            tiles_left  = 0;
            cell_column = 0;
            cell_row    = 0;
         end
         rtld_pkg::MODE_BYTE: begin
            case (tile_phase)
               EXPECT_CTRL: begin
                  // count clipped at the row end, zero count stays in control
                  count = 32'(item.stream_byte[rtld_pkg::COUNT_W-1:0]);
                  if (count > ROW_CELLS - cell_column)
                     count = ROW_CELLS - cell_column;
                  if (count != 0) begin
                     tiles_left = count;
                     tile_phase = item.stream_byte[rtld_pkg::LIT_BIT] ?
                                  EXPECT_LIT_TILE : EXPECT_RUN_TILE;
                  end
               end
               EXPECT_RUN_TILE: begin
                  while (tiles_left != 0) begin
                     tiles_left--;
                     emit_cell(item.stream_byte, tiles_left == 0);
                  end
                  tile_phase = EXPECT_CTRL;
               end
               default: begin
                  if (tiles_left != 0)
                     tiles_left--;
                  emit_cell(item.stream_byte, 1'b1);
                  if (tiles_left == 0)
                     tile_phase = EXPECT_CTRL;
               end
            endcase
         end
         default: ;
      endcase
   endfunction

   // item of the given mode with every field random
   function automatic rtld_pkg::req_type random_item(input logic [1:0] mode);
      rtld_pkg::req_type item;
      item.mode         = mode;
      item.stream_byte  = 8'($urandom);
      item.entry_index  = 8'($urandom);
      item.entry_char   = 8'($urandom);
      item.entry_colour = 4'($urandom);
      return item;
   endfunction

   // tile index of an entry that has been written
   function automatic logic [7:0] loaded_tile();
      return 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
   endfunction

   // one input transfer, with an optional idle burst ahead of it
   task automatic send_item(input rtld_pkg::req_type item, input logic typed,
                            input rtld_pkg::rsp_type typed_cell);
      int unsigned queued;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      queued = cells_due.size();
      decode_item(item);
      if (typed) begin
         while (cells_due.size() > queued)
            void'(cells_due.pop_back());
         cells_due.push_back(typed_cell);
      end
   endtask

   // result side: random stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b1;
         stall_left = 0;
      end else if (stall_left != 0) begin
         stall_left--;
         if (stall_left == 0)
            rsp_ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 6);
         rsp_ready <= 1'b0;
      end
   end

   // compare each cell transfer with the oldest expected cell
   always @(posedge clock) begin
      rtld_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (cells_due.size() == 0) begin
            $error("unexpected cell transfer at offset %0d", rsp_data.cell_offset);
            error_count++;
         end else begin
            want = cells_due.pop_front();
            if (rsp_data.cell_offset !== want.cell_offset) begin
               $error("cell_offset: expected %0d, got %0d", want.cell_offset,
                      rsp_data.cell_offset);
               error_count++;
            end
            if (rsp_data.char_code !== want.char_code) begin
               $error("char_code: expected %0h, got %0h", want.char_code, rsp_data.char_code);
               error_count++;
            end
            if (rsp_data.colour_value !== want.colour_value) begin
               $error("colour_value: expected %0h, got %0h", want.colour_value,
                      rsp_data.colour_value);
               error_count++;
            end
            if (rsp_data.last_of_item !== want.last_of_item) begin
               $error("last_of_item: expected %0b, got %0b", want.last_of_item,
                      rsp_data.last_of_item);
               error_count++;
            end
            if (rsp_data.picture_done !== want.picture_done) begin
               $error("picture_done: expected %0b, got %0b", want.picture_done,
                      rsp_data.picture_done);
               error_count++;
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int unsigned       random_sent;
      int unsigned       pick;
      int unsigned       count;
      logic              lit;
      rtld_pkg::req_type item;

      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;

      tile_phase  = EXPECT_CTRL;
      tiles_left  = 0;
      cell_column = 0;
      cell_row    = 0;
      tile_loaded = '0;
      idle_on     = 1'b1;

      // directed table: extremes, zero counts, clipping, ignored mode, restarts
      directed_rows[0]  = {rtld_pkg::MODE_LOAD,  8'hFF, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[1]  = {rtld_pkg::MODE_LOAD,  8'h00, 8'hFF, 8'hFF, 4'hF, 1'b0, NO_CELL};
      directed_rows[2]  = {rtld_pkg::MODE_LOAD,  8'h00, 8'h5A, 8'hA5, 4'h9, 1'b0, NO_CELL};
      directed_rows[3]  = {rtld_pkg::MODE_BYTE,  8'h81, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[4]  = {rtld_pkg::MODE_BYTE,  8'hFF, 8'h00, 8'h00, 4'h0, 1'b1,
                           {10'd0, 8'hFF, 4'hF, 1'b1, 1'b0}};
      directed_rows[5]  = {rtld_pkg::MODE_BYTE,  8'h81, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[6]  = {rtld_pkg::MODE_BYTE,  8'h00, 8'h00, 8'h00, 4'h0, 1'b1,
                           {10'd1, 8'h00, 4'h0, 1'b1, 1'b0}};
      directed_rows[7]  = {rtld_pkg::MODE_BYTE,  8'h00, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[8]  = {rtld_pkg::MODE_BYTE,  8'h80, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[9]  = {rtld_pkg::MODE_BYTE,  8'h03, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[10] = {rtld_pkg::MODE_BYTE,  8'h5A, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[11] = {rtld_pkg::MODE_BYTE,  8'h7F, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[12] = {rtld_pkg::MODE_BYTE,  8'hFF, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[13] = {rtld_pkg::MODE_BYTE,  8'hFF, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[14] = {rtld_pkg::MODE_BYTE,  8'h5A, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[15] = {rtld_pkg::MODE_BYTE,  8'h00, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[16] = {MODE_UNUSED,          8'h42, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[17] = {rtld_pkg::MODE_START, 8'h00, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[18] = {rtld_pkg::MODE_BYTE,  8'h82, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[19] = {rtld_pkg::MODE_BYTE,  8'hFF, 8'h00, 8'h00, 4'h0, 1'b1,
                           {10'd0, 8'hFF, 4'hF, 1'b1, 1'b0}};
      directed_rows[20] = {rtld_pkg::MODE_START, 8'hFF, 8'hFF, 8'hFF, 4'hF, 1'b0, NO_CELL};
      directed_rows[21] = {rtld_pkg::MODE_BYTE,  8'h01, 8'h00, 8'h00, 4'h0, 1'b0, NO_CELL};
      directed_rows[22] = {rtld_pkg::MODE_BYTE,  8'h00, 8'h00, 8'h00, 4'h0, 1'b1,
                           {10'd0, 8'h00, 4'h0, 1'b1, 1'b0}};
      directed_rows[23] = {MODE_UNUSED,          8'hFF, 8'hFF, 8'hFF, 4'hF, 1'b0, NO_CELL};

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++)
         send_item(directed_rows[i].item, directed_rows[i].typed,
                   directed_rows[i].want_cell);

      // hold the sender until every expected cell has come out
      req_valid <= 1'b0;
      do @(posedge clock); while (cells_due.size() != 0);

      // random part: mostly well-formed run and literal sequences
      random_sent = 0;
      while (random_sent < RANDOM_ITEMS) begin
         idle_on = !((random_sent >= 60 && random_sent < 100) || random_sent >= 160);
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_item(random_item(rtld_pkg::MODE_LOAD), 1'b0, NO_CELL);
            random_sent++;
         end else if (pick < 13) begin
            send_item(random_item(rtld_pkg::MODE_START), 1'b0, NO_CELL);
            random_sent++;
         end else if (pick < 15) begin
            send_item(random_item(MODE_UNUSED), 1'b0, NO_CELL);
         end else begin
            // control byte: mostly short counts, some long ones, a few zero
            item = random_item(rtld_pkg::MODE_BYTE);
            lit  = 1'($urandom_range(0, 1));
            pick = $urandom_range(0, 9);
            if (pick == 0)
               count = 0;
            else if (pick < 3)
               count = $urandom_range(0, 127);
            else
               count = $urandom_range(1, lit ? 6 : 12);
            item.stream_byte = {lit, 7'(count)};
            send_item(item, 1'b0, NO_CELL);
            random_sent++;
            if (tile_phase == EXPECT_RUN_TILE) begin
               item = random_item(rtld_pkg::MODE_BYTE);
               item.stream_byte = loaded_tile();
               send_item(item, 1'b0, NO_CELL);
               random_sent++;
            end
            // literal tiles, now and then broken by a restart or a table load
            while (tile_phase == EXPECT_LIT_TILE) begin
               pick = $urandom_range(0, 39);
               if (pick == 0) begin
                  item = random_item(rtld_pkg::MODE_START);
               end else if (pick == 1) begin
                  item = random_item(rtld_pkg::MODE_LOAD);
               end else begin
                  item = random_item(rtld_pkg::MODE_BYTE);
                  item.stream_byte = loaded_tile();
               end
               send_item(item, 1'b0, NO_CELL);
               random_sent++;
            end
         end
      end

      // drain
      req_valid <= 1'b0;
      do @(posedge clock); while (cells_due.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
